FILE: hw/rtl/arx_pkg.sv
package arx_pkg;

    // Field widths of the plant model.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 12;
    localparam int DELAY_W  = 3;
    localparam int DATA_W   = 32;
    localparam int PROD_W   = SAMPLE_W + COEF_W;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } state_t;

    // Controls from the sequencer to the shared multiply-accumulate unit.
    typedef struct packed {
        logic init;     // load the accumulator with the start value
        logic prod_en;  // multiply the presented coefficient and sample
        logic sub;      // subtract this product instead of adding it
    } mac_ctrl_t;

endpackage

FILE: hw/rtl/arx_model_step.sv
// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+-------------------------------
// input     | in        | in_valid/in_stall | sample_in, noise_in
// output    | out       | out_valid/out_stall | sample_out
// config    | in/out    | APB, pready high  | paddr, pwdata, prdata
//
// Each word is handled in steps: the sequencer takes the word, then the single
// multiplier serves every tap, one tap a cycle, then the product register is
// drained and the result is rounded and saturated.
// Reset clears the coefficients, the delay and both sample histories.
// A stalled output holds the sequencer in the rounding step; the input stalls
// whenever a word is in flight.
module arx_model_step #(
    parameter int A_ORDER   = 3,
    parameter int B_ORDER   = 3,
    parameter int MAX_DELAY = 7,
    localparam int N_REGS   = A_ORDER + B_ORDER + 1,
    localparam int ADDR_W   = $clog2(4 * N_REGS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]  noise_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [arx_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ADDR_W-1:0]                    paddr,
    input  logic [arx_pkg::DATA_W-1:0]           pwdata,
    output logic [arx_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    localparam int HIST_DEPTH = B_ORDER + MAX_DELAY;
    localparam int N_TAPS     = A_ORDER + B_ORDER;
    localparam int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int AIDX_W     = (A_ORDER > 1) ? $clog2(A_ORDER) : 1;
    localparam int BIDX_W     = (B_ORDER > 1) ? $clog2(B_ORDER) : 1;
    localparam int TAP_W      = $clog2(N_TAPS);
    localparam int IDX_W      = ADDR_W - 2;
    localparam int ACC_W      = arx_pkg::PROD_W + 1 + $clog2(N_TAPS + 1);
    localparam int SHIFT_W    = ACC_W - arx_pkg::FRAC_W;
    localparam int EXT_W      = ACC_W - arx_pkg::SAMPLE_W - arx_pkg::FRAC_W;
    localparam int REG_B0     = A_ORDER;
    localparam int REG_DELAY  = A_ORDER + B_ORDER;

    arx_pkg::state_t state_reg;
    arx_pkg::state_t state_next;
    arx_pkg::mac_ctrl_t mac_ctrl;

    logic signed [arx_pkg::COEF_W-1:0]   a_coeff_reg [A_ORDER];
    logic signed [arx_pkg::COEF_W-1:0]   b_coeff_reg [B_ORDER];
    logic [arx_pkg::DELAY_W-1:0]         input_delay_reg;
    logic signed [arx_pkg::SAMPLE_W-1:0] in_hist_reg [HIST_DEPTH];
    logic signed [arx_pkg::SAMPLE_W-1:0] out_hist_reg [A_ORDER];
    logic [TAP_W-1:0]                    tap_reg;
    logic [TAP_W-1:0]                    tap_next;
    logic                                out_valid_reg;
    logic signed [arx_pkg::SAMPLE_W-1:0] sample_out_reg;

    logic                                accept;
    logic                                cfg_write;
    logic [IDX_W-1:0]                    cfg_idx;
    logic                                load_out;
    logic [HIDX_W-1:0]                   delay_k;
    logic [TAP_W-1:0]                    a_tap;
    logic signed [arx_pkg::COEF_W-1:0]   mac_coef;
    logic signed [arx_pkg::SAMPLE_W-1:0] mac_sample;
    logic signed [ACC_W-1:0]             init_value;
    logic signed [ACC_W-1:0]             acc;
    logic signed [SHIFT_W-1:0]           acc_shift;
    logic signed [arx_pkg::SAMPLE_W-1:0] y_sat;

    assign accept    = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign pready    = 1'b1;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and controls: one tap per cycle, then drain and round.
    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        in_stall     = 1'b1;
        load_out     = 1'b0;
        mac_ctrl     = '0;
        case (state_reg)
            arx_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                tap_next = '0;
                if (in_valid)
                begin
                    mac_ctrl.init = 1'b1;
                    state_next    = arx_pkg::ST_MAC;
                end
            end
            arx_pkg::ST_MAC:
            begin
                mac_ctrl.prod_en = 1'b1;
                mac_ctrl.sub     = (32'(tap_reg) >= B_ORDER);
                if (32'(tap_reg) == N_TAPS - 1)
                begin
                    state_next = arx_pkg::ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            arx_pkg::ST_DRAIN:
            begin
                state_next = arx_pkg::ST_ROUND;
            end
            arx_pkg::ST_ROUND:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = arx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arx_pkg::ST_IDLE;
            end
        endcase
    end

    // Dead time clamped to MAX_DELAY, so every input tap stays within the input history.
    always_comb
    begin
        if (32'(input_delay_reg) > MAX_DELAY)
        begin
            delay_k = HIDX_W'(MAX_DELAY);
        end
        else
        begin
            delay_k = HIDX_W'(input_delay_reg);
        end
    end

    // Operand select: input taps first, then the feedback taps.
    always_comb
    begin
        a_tap = tap_reg - TAP_W'(B_ORDER);
        if (32'(tap_reg) < B_ORDER)
        begin
            mac_coef   = b_coeff_reg[BIDX_W'(tap_reg)];
            mac_sample = in_hist_reg[delay_k + HIDX_W'(tap_reg)];
        end
        else
        begin
            mac_coef   = a_coeff_reg[AIDX_W'(a_tap)];
            mac_sample = out_hist_reg[AIDX_W'(a_tap)];
        end
    end

    // The accumulator starts at the disturbance in Q.12 plus half an LSB.
    assign init_value = {{EXT_W{noise_in[arx_pkg::SAMPLE_W-1]}}, noise_in,
                         1'b1, {(arx_pkg::FRAC_W-1){1'b0}}};

    arx_mac #(
        .ACC_W(ACC_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .coef      (mac_coef),
        .sample    (mac_sample),
        .init_value(init_value),
        .acc       (acc)
    );

    // Floor shift, then saturate when the upper bits are not all sign.
    always_comb
    begin
        acc_shift = acc[ACC_W-1:arx_pkg::FRAC_W];
        if ((&acc_shift[SHIFT_W-1:arx_pkg::SAMPLE_W-1]) ||
            !(|acc_shift[SHIFT_W-1:arx_pkg::SAMPLE_W-1]))
        begin
            y_sat = acc_shift[arx_pkg::SAMPLE_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            y_sat = {1'b1, {(arx_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(arx_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

    // Control registers: tap counter, output valid, sample histories, configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg         <= '0;
            out_valid_reg   <= 1'b0;
            input_delay_reg <= '0;
            for (int i = 0; i < A_ORDER; i++)
            begin
                a_coeff_reg[i] <= '0;
                out_hist_reg[i] <= '0;
            end
            for (int i = 0; i < B_ORDER; i++)
            begin
                b_coeff_reg[i] <= '0;
            end
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                in_hist_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg <= tap_next;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Input history shifts as a word is taken.
            if (accept)
            begin
                in_hist_reg[0] <= sample_in;
                for (int i = 1; i < HIST_DEPTH; i++)
                begin
                    in_hist_reg[i] <= in_hist_reg[i-1];
                end
            end

            // Output history shifts as the saturated result leaves.
            if (load_out)
            begin
                out_hist_reg[0] <= y_sat;
                for (int i = 1; i < A_ORDER; i++)
                begin
                    out_hist_reg[i] <= out_hist_reg[i-1];
                end
            end

            if (cfg_write)
            begin
                for (int i = 0; i < A_ORDER; i++)
                begin
                    if (32'(cfg_idx) == i)
                    begin
                        a_coeff_reg[i] <= pwdata[arx_pkg::COEF_W-1:0];
                    end
                end
                for (int i = 0; i < B_ORDER; i++)
                begin
                    if (32'(cfg_idx) == REG_B0 + i)
                    begin
                        b_coeff_reg[i] <= pwdata[arx_pkg::COEF_W-1:0];
                    end
                end
                if (32'(cfg_idx) == REG_DELAY)
                begin
                    input_delay_reg <= pwdata[arx_pkg::DELAY_W-1:0];
                end
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_out_reg <= y_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // Register readback.
    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < A_ORDER; i++)
        begin
            if (32'(cfg_idx) == i)
            begin
                prdata = arx_pkg::DATA_W'(a_coeff_reg[i]);
            end
        end
        for (int i = 0; i < B_ORDER; i++)
        begin
            if (32'(cfg_idx) == REG_B0 + i)
            begin
                prdata = arx_pkg::DATA_W'(b_coeff_reg[i]);
            end
        end
        if (32'(cfg_idx) == REG_DELAY)
        begin
            prdata = arx_pkg::DATA_W'(input_delay_reg);
        end
    end

`ifndef SYNTH
    // A new result appears only out of the rounding step.
    a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == arx_pkg::ST_ROUND))
        else $error("output word raised outside the rounding step");

    // An accepted word stalls the input and starts the tap sequence.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && state_reg == arx_pkg::ST_MAC))
        else $error("input not stalled after an accepted word");

    // The tap counter never runs past the last tap.
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arx_pkg::ST_MAC) |-> (32'(tap_reg) < N_TAPS))
        else $error("tap counter beyond the last tap");
`endif

endmodule

FILE: hw/rtl/arx_mac.sv
module arx_mac #(
    parameter int ACC_W = 36
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  arx_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [arx_pkg::COEF_W-1:0]   coef,
    input  logic signed [arx_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [ACC_W-1:0]             init_value,
    output logic signed [ACC_W-1:0]             acc
);

    logic signed [arx_pkg::PROD_W-1:0] prod_reg;
    logic                              sub_reg;
    logic                              pvalid_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;
    logic signed [ACC_W-1:0]           prod_ext;

    // Product stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctrl.prod_en;
        end
    end

    // Registered multiplier; the sign control travels with its product.
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_reg <= coef * sample;
            sub_reg  <= ctrl.sub;
        end
    end

    // Accumulator loads the start value, or adds or subtracts the previous cycle's product.
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        acc_next = acc_reg;
        if (ctrl.init)
        begin
            acc_next = init_value;
        end
        else if (pvalid_reg)
        begin
            acc_next = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: dv/arx_checker.sv
module arx_checker #(
    parameter int A_ORDER   = 3,
    parameter int B_ORDER   = 3,
    parameter int MAX_DELAY = 7,
    parameter int ADDR_W    = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]  noise_in,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [ADDR_W-1:0]                    paddr,
    input  logic [arx_pkg::DATA_W-1:0]           pwdata,
    output int                                   mismatches,
    output int                                   pending
);

    localparam int HIST_DEPTH = B_ORDER + MAX_DELAY;

    typedef logic signed [arx_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic signed [arx_pkg::COEF_W-1:0]   coef_t;

    // Private copy of the plant state and its settings.
    sample_t          u_hist [HIST_DEPTH];
    sample_t          y_hist [A_ORDER];
    coef_t            coef_a [A_ORDER];
    coef_t            coef_b [B_ORDER];
    logic [arx_pkg::DELAY_W-1:0] dead_time;

    // Plant outputs still owed by the block, oldest first.
    sample_t          owed_outputs [$];
    int               fail_count;

    // Advances the plant by one sample and returns the saturated output.
    function automatic sample_t plant_output(sample_t u, sample_t e);
        longint  acc;
        longint  rounded;
        longint  rail;
        int      k;
        sample_t y;
        k = (int'(dead_time) > MAX_DELAY) ? MAX_DELAY : int'(dead_time);
        for (int n = HIST_DEPTH - 1; n > 0; n--)
            u_hist[n] = u_hist[n - 1];
        u_hist[0] = u;

        // Exact sum at Q.12 scale, the disturbance lifted to the same scale.
        acc = longint'(e) <<< arx_pkg::FRAC_W;
        for (int n = 0; n < B_ORDER; n++)
            acc += longint'(coef_b[n]) * longint'(u_hist[k + n]);
        for (int n = 0; n < A_ORDER; n++)
            acc -= longint'(coef_a[n]) * longint'(y_hist[n]);

        // Round half up, then clamp to the sample range.
        rounded = acc + (longint'(1) <<< (arx_pkg::FRAC_W - 1));
        rail    = longint'(1) <<< (arx_pkg::SAMPLE_W - 1 + arx_pkg::FRAC_W);
        if (rounded >= rail)
            y = {1'b0, {(arx_pkg::SAMPLE_W - 1){1'b1}}};
        else if (rounded < -rail)
            y = {1'b1, {(arx_pkg::SAMPLE_W - 1){1'b0}}};
        else
            y = sample_t'(rounded >>> arx_pkg::FRAC_W);

        for (int n = A_ORDER - 1; n > 0; n--)
            y_hist[n] = y_hist[n - 1];
        y_hist[0] = y;
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int      idx;
        sample_t want;
        if (!rst_n)
        begin
            foreach (u_hist[n]) u_hist[n] = '0;
            foreach (y_hist[n]) y_hist[n] = '0;
            foreach (coef_a[n]) coef_a[n] = '0;
            foreach (coef_b[n]) coef_b[n] = '0;
            dead_time = '0;
            owed_outputs.delete();
            fail_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // Follow register writes on the configuration bus.
            if (psel && penable && pwrite && pready)
            begin
                idx = int'(paddr) / 4;
                if (idx < A_ORDER)
                    coef_a[idx] = pwdata[arx_pkg::COEF_W-1:0];
                else if (idx < A_ORDER + B_ORDER)
                    coef_b[idx - A_ORDER] = pwdata[arx_pkg::COEF_W-1:0];
                else if (idx == A_ORDER + B_ORDER)
                    dead_time = pwdata[arx_pkg::DELAY_W-1:0];
            end

            // Every accepted input word owes exactly one output word.
            if (in_valid && !in_stall)
                owed_outputs.push_back(plant_output(sample_in, noise_in));

            // Compare each delivered word against the oldest one owed.
            if (out_valid && !out_stall)
            begin
                if (owed_outputs.size() == 0)
                begin
                    $display("%0t checker: unexpected sample_out %0d, nothing owed",
                             $time, sample_out);
                    fail_count++;
                end
                else
                begin
                    want = owed_outputs.pop_front();
                    if (sample_out !== want)
                    begin
                        $display("%0t checker: sample_out expected %0d got %0d",
                                 $time, want, sample_out);
                        fail_count++;
                    end
                end
            end

            mismatches <= fail_count;
            pending    <= owed_outputs.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;

    localparam int A_ORDER   = 3;
    localparam int B_ORDER   = 3;
    localparam int MAX_DELAY = 7;
    localparam int N_REGS    = A_ORDER + B_ORDER + 1;
    localparam int ADDR_W    = $clog2(4 * N_REGS);

    // Register map, one word per register.
    localparam int REG_A1     = 0;
    localparam int REG_A2     = 1;
    localparam int REG_A3     = 2;
    localparam int REG_B1     = 3;
    localparam int REG_B2     = 4;
    localparam int REG_B3     = 5;
    localparam int REG_DELAY  = 6;
    localparam int REG_UNUSED = 7;

    localparam int DELAY_TOP      = 7;
    localparam int SETTLE_CYCLES  = A_ORDER + B_ORDER + 10;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_WORDS    = 127;
    localparam int CYCLE_LIMIT    = 1_000_000;

    typedef logic signed [arx_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic signed [arx_pkg::COEF_W-1:0]   coef_t;

    // How coefficients are drawn for a phase.
    typedef enum int {
        MIX_FULL,
        MIX_STABLE,
        MIX_RAIL
    } coef_mix_t;

    localparam sample_t S_MAX = 16'sh7FFF;
    localparam sample_t S_MIN = 16'sh8000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    sample_t              sample_in = '0;
    sample_t              noise_in  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    sample_t              sample_out;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_W-1:0]    paddr     = '0;
    logic [arx_pkg::DATA_W-1:0] pwdata = '0;
    logic [arx_pkg::DATA_W-1:0] prdata;
    logic                 pready;

    int                   mismatches;
    int                   pending;
    int                   cycle_count = 0;
    bit                   quiet = 1'b0;
    bit                   hold_request = 1'b0;

    always #2 clk = ~clk;

    arx_model_step u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .noise_in   (noise_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    arx_checker #(
        .A_ORDER   (A_ORDER),
        .B_ORDER   (B_ORDER),
        .MAX_DELAY (MAX_DELAY),
        .ADDR_W    (ADDR_W)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .noise_in   (noise_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t random_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return sample_t'($urandom());
        if (roll < 9)
            return sample_t'(int'($urandom_range(0, 400)) - 200);
        return $urandom_range(0, 1) ? S_MAX : S_MIN;
    endfunction

    function automatic sample_t random_noise();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return sample_t'(int'($urandom_range(0, 127)) - 64);
        if (roll < 85)
            return sample_t'($urandom());
        if (roll < 92)
            return S_MAX;
        if (roll < 97)
            return S_MIN;
        return '0;
    endfunction

    function automatic coef_t pick_coef(coef_mix_t mix, bit feedback);
        int roll;
        roll = $urandom_range(0, 3);
        case (mix)
            MIX_FULL:
                return coef_t'($urandom());
            MIX_STABLE:
                if (feedback)
                    return coef_t'(int'($urandom_range(0, 2000)) - 1000);
                else
                    return coef_t'(int'($urandom_range(0, 8192)) - 4096);
            default:
                if (roll == 0)
                    return 16'sh7FFF;
                else if (roll == 1)
                    return 16'sh8000;
                else if (roll == 2)
                    return '0;
                else
                    return coef_t'($urandom());
        endcase
    endfunction

    // One register write: a setup phase, an access phase held until pready, then idle.
    task automatic config_write(input int idx, input logic [arx_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Coefficients keep random upper bits to show only the low half counts.
    task automatic write_coef(input int idx, input coef_t c);
        config_write(idx, {16'($urandom()), c});
    endtask

    task automatic write_delay(input int k);
        config_write(REG_DELAY, {29'($urandom()), 3'(k)});
    endtask

    task automatic program_plant(input coef_mix_t mix, input int k);
        write_coef(REG_A1, pick_coef(mix, 1'b1));
        write_coef(REG_A2, pick_coef(mix, 1'b1));
        write_coef(REG_A3, pick_coef(mix, 1'b1));
        write_coef(REG_B1, pick_coef(mix, 1'b0));
        write_coef(REG_B2, pick_coef(mix, 1'b0));
        write_coef(REG_B3, pick_coef(mix, 1'b0));
        write_delay(k);
        if ($urandom_range(0, 1))
            config_write(REG_UNUSED, $urandom());
    endtask

    // Offer one word after a random gap and hold it until accepted.
    task automatic send_word(input sample_t u, input sample_t e);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= u;
        noise_in  <= e;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait until every owed output word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output side back-pressure, with one long hold on request.
    initial
    begin : receiver
        int stall_len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall_len = idle_len();
            if (hold_request)
            begin
                stall_len    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        sample_t   held_u;
        coef_mix_t mix;
        int        k;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the output is the disturbance alone.
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        send_word('0, '0);
        send_word(-16'sd1, 16'sd1);
        send_word(16'sh5555, 16'shAAAA);
        drain();

        // Half gain on the current input: exact halves round upward.
        write_coef(REG_A1, '0);
        write_coef(REG_A2, '0);
        write_coef(REG_A3, '0);
        write_coef(REG_B1, 16'sd2048);
        write_coef(REG_B2, '0);
        write_coef(REG_B3, '0);
        write_delay(0);
        config_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_word(16'sd1, '0);
        send_word(-16'sd1, '0);
        send_word(16'sd3, '0);
        send_word(-16'sd3, '0);
        drain();

        // Extreme coefficients and the longest dead time: saturation both ways.
        write_coef(REG_A1, 16'sh8000);
        write_coef(REG_A2, 16'sh7FFF);
        write_coef(REG_A3, 16'sh8000);
        write_coef(REG_B1, 16'sh7FFF);
        write_coef(REG_B2, 16'sh8000);
        write_coef(REG_B3, 16'sh7FFF);
        write_delay(DELAY_TOP);
        for (int i = 0; i < 12; i++)
            send_word(i[0] ? S_MIN : S_MAX, i[1] ? S_MAX : S_MIN);
        drain();

        // Full gain, no dead time, no feedback.
        write_coef(REG_A1, '0);
        write_coef(REG_A2, '0);
        write_coef(REG_A3, '0);
        write_coef(REG_B1, 16'sh7FFF);
        write_coef(REG_B2, '0);
        write_coef(REG_B3, '0);
        write_delay(0);
        send_word(S_MAX, S_MAX);
        send_word(S_MIN, S_MIN);
        drain();

        // Random phases: step-like input runs under varied settings.
        held_u = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            quiet = (ph % 4 == 1);
            mix   = coef_mix_t'(ph % 3);
            if (ph == 0)
                k = 0;
            else if (ph == 1)
                k = DELAY_TOP;
            else
                k = $urandom_range(0, DELAY_TOP);
            program_plant(mix, k);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (ph == 2 && i == 30)
                    hold_request = 1'b1;
                if (ph == 4 && i == 60)
                    drain();
                if (i == 0 || $urandom_range(0, 3) == 0)
                    held_u = random_sample();
                send_word(held_u, random_noise());
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: arx_model_step.f
hw/rtl/arx_pkg.sv
hw/rtl/arx_mac.sv
hw/rtl/arx_model_step.sv
dv/arx_checker.sv
dv/tb_top.sv
